// File: src/aes_pkg.sv
// package for the aes-128 encryption pipeline
// holds payload structs, the sbox table and round helper functions; no dependencies
package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 1'd1;

    typedef struct packed {
        logic [63:0] plain_upper;
        logic [63:0] plain_lower;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] cipher_upper;
        logic [63:0] cipher_lower;
    } aes_out_t;

    typedef logic [127:0] aes_state_t;
    typedef logic [127:0] aes_rkey_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // round constants for key expansion rounds 1..10
    localparam logic [7:0] RCON [ROUND_COUNT] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // byte k of the block sits at bits 127-8k
    function automatic logic [7:0] get_byte(input aes_state_t s, input int k);
        get_byte = s[127-8*k -: 8];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // subbytes plus shiftrows
    function automatic aes_state_t sub_shift(input aes_state_t s);
        aes_state_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
        sub_shift = t;
    endfunction

    function automatic aes_state_t mix_cols(input aes_state_t s);
        aes_state_t t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0  = get_byte(s, 4*c);
            a1  = get_byte(s, 4*c+1);
            a2  = get_byte(s, 4*c+2);
            a3  = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127-8*(4*c)   -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
            t[127-8*(4*c+1) -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
            t[127-8*(4*c+2) -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
            t[127-8*(4*c+3) -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
        mix_cols = t;
    endfunction

    // one step of the key schedule: previous round key to next
    function automatic aes_rkey_t next_rkey(input aes_rkey_t k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
             ^ {rc, 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_rkey = {w0, w1, w2, w3};
    endfunction

endpackage

// File: src/aes_key_sched.sv
// key schedule: expands the configured key into all eleven round keys
// one schedule step per register stage after a key write; depends on aes_pkg
module aes_key_sched (
    input  logic                        clk,
    input  logic                        rst_n,
    input  aes_pkg::aes_rkey_t          cipher_key,
    output aes_pkg::aes_rkey_t          round_keys [aes_pkg::ROUND_COUNT+1]
);
    import aes_pkg::*;

    // round keys 1..10; entry i holds round key i+1
    aes_rkey_t rkey_reg [ROUND_COUNT];

    // round key 0 is the key itself, the rest come from the chain
    always_comb
    begin
        round_keys[0] = cipher_key;
        for (int i = 1; i <= ROUND_COUNT; i++)
            round_keys[i] = rkey_reg[i-1];
    end

    // chain of expansion registers, each step from the previous one,
    // moving in step with the data so round key n reaches stage n in time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROUND_COUNT; i++)
                rkey_reg[i] <= '0;
        end
        else
        begin
            rkey_reg[0] <= next_rkey(cipher_key, RCON[0]);
            for (int i = 1; i < ROUND_COUNT; i++)
                rkey_reg[i] <= next_rkey(rkey_reg[i-1], RCON[i]);
        end
    end

endmodule

// File: src/aes_round.sv
// one cipher round stage: subbytes, shiftrows, optional mixcolumns, addroundkey
// registered output with valid; depends on aes_pkg
module aes_round (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                last_round,
    input  logic                in_valid,
    input  aes_pkg::aes_state_t in_state,
    input  aes_pkg::aes_rkey_t  round_key,
    output logic                out_valid,
    output aes_pkg::aes_state_t out_state
);
    import aes_pkg::*;

    logic       valid_reg;
    aes_state_t state_reg;
    aes_state_t state_next;
    aes_state_t shifted;

    // round datapath
    always_comb
    begin
        shifted    = sub_shift(in_state);
        state_next = (last_round ? shifted : mix_cols(shifted)) ^ round_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

// File: src/aes128_block_encrypt.sv
// top level of the aes-128 encryption pipeline
// key registers, key schedule and eleven stages; depends on aes_pkg, aes_key_sched, aes_round
//
// Pipelined AES-128 encryptor: one block is taken each cycle that start is high (busy is
// always low), and its ciphertext appears with done high after it has passed the initial
// key add stage and then one round stage per round, ten rounds. Results cannot be stalled.
// A key write applies to every block started from the next cycle on: the key schedule
// registers round key n in the cycle after round key n-1, in step with the data.
// Write the key only while no block is in flight.
module aes128_block_encrypt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  aes_pkg::aes_in_t                 din,
    output logic                             done,
    output aes_pkg::aes_out_t                dout,
    input  logic                             cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [aes_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import aes_pkg::*;

    logic [63:0] key_upper_reg;
    logic [63:0] key_lower_reg;
    aes_rkey_t   round_keys [ROUND_COUNT+1];
    logic        stg_valid [ROUND_COUNT+1];
    aes_state_t  stg_state [ROUND_COUNT+1];
    logic        valid0_reg;
    aes_state_t  state0_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_KEY_UPPER: key_upper_reg <= cfg_data;
                REG_KEY_LOWER: key_lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_key_sched u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cipher_key ({key_upper_reg, key_lower_reg}),
        .round_keys (round_keys)
    );

    // initial key add stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid0_reg <= 1'b0;
        else
            valid0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            state0_reg <= {din.plain_upper, din.plain_lower} ^ round_keys[0];
    end

    assign stg_valid[0] = valid0_reg;
    assign stg_state[0] = state0_reg;

    // round stages
    for (genvar g = 1; g <= ROUND_COUNT; g++)
    begin : g_round
        aes_round u_round (
            .clk        (clk),
            .rst_n      (rst_n),
            .last_round (g == ROUND_COUNT),
            .in_valid   (stg_valid[g-1]),
            .in_state   (stg_state[g-1]),
            .round_key  (round_keys[g]),
            .out_valid  (stg_valid[g]),
            .out_state  (stg_state[g])
        );
    end

    assign busy = 1'b0;
    assign done = stg_valid[ROUND_COUNT];
    assign dout.cipher_upper = stg_state[ROUND_COUNT][127:64];
    assign dout.cipher_lower = stg_state[ROUND_COUNT][63:0];

    // a beat in the initial key add stage must come out with done after the ten round stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid[0] |-> ##10 done)
        else $error("result beat missing");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !stg_valid[0] |-> ##10 !done)
        else $error("unexpected result beat");
    a_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> stg_valid[0])
        else $error("accepted beat not in first stage");

endmodule
